[rtl/life_generation_torus_macros.svh]
// Assertion macros for the life board engine.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef LIFE_GENERATION_TORUS_MACROS_SVH
`define LIFE_GENERATION_TORUS_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define LGT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LGT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LGT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LGT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/lgt_pkg.sv]
// Shared types and constants for the life board engine.
// No dependencies; used by lgt_row_rule and life_generation_torus.
`timescale 1ns / 1ps
`default_nettype none

package lgt_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Command codes
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  // B3/S23 neighbor counts
  localparam logic [3:0] NBR_KEEP  = 4'd2;
  localparam logic [3:0] NBR_BIRTH = 4'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] row;
    logic [5:0] col;
    logic       cell_in;
  } in_t;

  typedef struct packed {
    logic cell_out;
    logic status;
  } out_t;

endpackage

`default_nettype wire

[rtl/lgt_row_rule.sv]
// Next-generation row from a three-row window, columns wrapping at the board width.
// Depends on lgt_pkg for the neighbor-count constants.
`timescale 1ns / 1ps
`default_nettype none

module lgt_row_rule #(
  parameter int MAX_WIDTH = lgt_pkg::DEF_MAX_WIDTH
) (
  input  wire logic [MAX_WIDTH-1:0]                row_up,
  input  wire logic [MAX_WIDTH-1:0]                row_mid,
  input  wire logic [MAX_WIDTH-1:0]                row_dn,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      wid,
  output logic      [MAX_WIDTH-1:0]                nxt_row
);
  import lgt_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [CLW-1:0] wm1;

  // last column in use, the left neighbor of column zero
  assign wm1 = CLW'(wid - WW'(1));

  for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
    localparam int CL = (c == 0) ? 0 : c - 1;
    localparam int CR = (c + 1 < MAX_WIDTH) ? c + 1 : 0;

    logic [2:0] lft;
    logic [2:0] rgt;
    logic [3:0] cnt;

    assign lft = (c == 0) ? {row_up[wm1], row_mid[wm1], row_dn[wm1]}
                          : {row_up[CL], row_mid[CL], row_dn[CL]};
    assign rgt = (WW'(c + 1) == wid) ? {row_up[0], row_mid[0], row_dn[0]}
                                     : {row_up[CR], row_mid[CR], row_dn[CR]};
    assign cnt = 4'(lft[0]) + 4'(lft[1]) + 4'(lft[2]) +
                 4'(rgt[0]) + 4'(rgt[1]) + 4'(rgt[2]) +
                 4'(row_up[c]) + 4'(row_dn[c]);

    // drop columns outside the board in use
    assign nxt_row[c] = (WW'(c) < wid) &&
                        ((cnt == NBR_BIRTH) || (row_mid[c] && (cnt == NBR_KEEP)));
  end

endmodule

`default_nettype wire

[rtl/life_generation_torus.sv]
// Top level of the toroidal B3/S23 life board engine.
// Depends on lgt_pkg, lgt_row_rule and life_generation_torus_macros.svh.
// The board lives in one memory of 2*MAX_HEIGHT rows, MAX_WIDTH bits each, two banks
// of MAX_HEIGHT rows. Items are taken one at a time: a cell write or read goes through
// a row read, then modify or pick with the write back, then the result register; an
// out-of-range or unused command goes straight to the result register. An advance
// streams the current bank through a three-row window at one row per cycle on the
// memory read port, writes each new row on the write port, then zeroes the unused
// rows of the new bank, if any. After reset a clearing pass writes bank 0 one row per
// cycle with in_ready low; configuration writes are taken throughout. The result
// register lets the next item be taken while a result still waits.
`timescale 1ns / 1ps
`default_nettype none
`include "life_generation_torus_macros.svh"

module life_generation_torus #(
  parameter int MAX_WIDTH  = lgt_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lgt_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire lgt_pkg::in_t                     in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output lgt_pkg::out_t                         out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lgt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lgt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lgt_pkg::*;

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SW   = $clog2(MAX_HEIGHT + 3);
  localparam int AW   = $clog2(2 * MAX_HEIGHT);
  localparam int CLW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int DW   = (HW > 6) ? HW : 6;
  localparam int HRST = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_MOD  = 3'd3;
  localparam logic [2:0] ST_ADV  = 3'd4;
  localparam logic [2:0] ST_AZR  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [MAX_WIDTH-1:0] mem [2*MAX_HEIGHT];

  logic [2:0]           state_r, state_nxt;
  logic [RW-1:0]        clr_r, clr_nxt;
  logic                 bank_r, bank_nxt;
  logic [WW-1:0]        wid_r, wid_nxt;
  logic [HW-1:0]        hgt_r, hgt_nxt;
  in_t                  req_r, req_nxt;
  out_t                 res_r, res_nxt;
  logic                 out_vld_r, out_vld_nxt;
  out_t                 out_r, out_nxt;
  logic [SW-1:0]        sc_r, sc_nxt;
  logic                 s1_vld_r, s1_vld_nxt;
  logic [SW-1:0]        s1_k_r;
  logic                 win_vld_r, win_vld_nxt;
  logic [SW-1:0]        win_k_r;
  logic [MAX_WIDTH-1:0] win_up_r, win_mid_r, win_dn_r;
  logic [RW-1:0]        zr_r, zr_nxt;
  logic [MAX_WIDTH-1:0] rd_data_r;

  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [MAX_WIDTH-1:0] wr_data;
  logic [MAX_WIDTH-1:0] nxt_row;
  logic [SW-1:0]        hsw;
  logic [SW-1:0]        sw_row;
  logic [RW-1:0]        win_row;
  logic                 rd_issue;
  logic                 oor;
  logic [CLW-1:0]       cix;
  int                   cfg_v;

  function automatic logic [AW-1:0] row_addr(input logic bank, input logic [RW-1:0] r);
    row_addr = bank ? (AW'(MAX_HEIGHT) + AW'(r)) : AW'(r);
  endfunction

  assign hsw      = SW'(hgt_r);
  assign rd_issue = (state_r == ST_ADV) && (sc_r <= hsw + SW'(1));
  // sweep order: last row, rows 0..h-1, then row 0 again
  assign sw_row   = (sc_r == '0) ? (hsw - SW'(1))
                  : (((sc_r - SW'(1)) == hsw) ? '0 : (sc_r - SW'(1)));
  assign win_row  = RW'(win_k_r - SW'(2));
  assign cix      = CLW'(req_r.col);
  assign oor      = (DW'(in_data.row) >= DW'(hgt_r)) || (7'(in_data.col) >= 7'(wid_r));

  lgt_row_rule #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_rule (
    .row_up  (win_up_r),
    .row_mid (win_mid_r),
    .row_dn  (win_dn_r),
    .wid     (wid_r),
    .nxt_row (nxt_row)
  );

  // memory ports
  always_comb begin
    rd_addr = row_addr(bank_r, RW'(req_r.row));
    if (state_r == ST_ADV) begin
      rd_addr = row_addr(bank_r, RW'(sw_row));
    end
    wr_en   = 1'b0;
    wr_addr = row_addr(~bank_r, zr_r);
    wr_data = '0;
    case (state_r)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = row_addr(1'b0, clr_r);
      end
      ST_MOD: begin
        wr_en   = (req_r.command == CMD_WRITE);
        wr_addr = row_addr(bank_r, RW'(req_r.row));
        wr_data = rd_data_r;
        wr_data[cix] = req_r.cell_in;
      end
      ST_ADV: begin
        wr_en   = win_vld_r;
        wr_addr = row_addr(~bank_r, win_row);
        wr_data = nxt_row;
      end
      ST_AZR: begin
        wr_en   = 1'b1;
      end
      default: begin
        wr_en   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // configuration, clamped to the legal board size
  always_comb begin
    wid_nxt = wid_r;
    hgt_nxt = hgt_r;
    cfg_v   = int'(cfg_data);
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WIDTH) begin
        wid_nxt = WW'((cfg_v == 0) ? 1 : ((cfg_v > MAX_WIDTH) ? MAX_WIDTH : cfg_v));
      end else if (cfg_index == CFG_HEIGHT) begin
        hgt_nxt = HW'((cfg_v == 0) ? 1 : ((cfg_v > MAX_HEIGHT) ? MAX_HEIGHT : cfg_v));
      end
    end
  end

  // control
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    bank_nxt    = bank_r;
    req_nxt     = req_r;
    res_nxt     = res_r;
    sc_nxt      = sc_r;
    zr_nxt      = zr_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_ready;
    s1_vld_nxt  = rd_issue;
    win_vld_nxt = s1_vld_r && (s1_k_r >= SW'(2));
    case (state_r)
      ST_CLR: begin
        clr_nxt = clr_r + RW'(1);
        if (clr_r == RW'(MAX_HEIGHT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          res_nxt = '0;
          if ((in_data.command == CMD_WRITE) || (in_data.command == CMD_READ)) begin
            if (oor) begin
              res_nxt.status = 1'b1;
              state_nxt      = ST_DONE;
            end else begin
              state_nxt      = ST_RD;
            end
          end else if (in_data.command == CMD_ADVANCE) begin
            sc_nxt    = '0;
            state_nxt = ST_ADV;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (req_r.command == CMD_READ) begin
          res_nxt.cell_out = rd_data_r[cix];
        end
        state_nxt = ST_DONE;
      end
      ST_ADV: begin
        if (rd_issue) begin
          sc_nxt = sc_r + SW'(1);
        end
        if (win_vld_r && (win_k_r == hsw + SW'(1))) begin
          if (int'(hgt_r) == MAX_HEIGHT) begin
            bank_nxt  = ~bank_r;
            state_nxt = ST_DONE;
          end else begin
            zr_nxt    = RW'(hgt_r);
            state_nxt = ST_AZR;
          end
        end
      end
      ST_AZR: begin
        zr_nxt = zr_r + RW'(1);
        if (zr_r == RW'(MAX_HEIGHT - 1)) begin
          bank_nxt  = ~bank_r;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_vld_r || out_ready) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      clr_r     <= '0;
      bank_r    <= 1'b0;
      wid_r     <= WW'(MAX_WIDTH);
      hgt_r     <= HW'(HRST);
      out_vld_r <= 1'b0;
      s1_vld_r  <= 1'b0;
      win_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      bank_r    <= bank_nxt;
      wid_r     <= wid_nxt;
      hgt_r     <= hgt_nxt;
      out_vld_r <= out_vld_nxt;
      s1_vld_r  <= s1_vld_nxt;
      win_vld_r <= win_vld_nxt;
    end
  end

  // payload and window registers
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    sc_r   <= sc_nxt;
    zr_r   <= zr_nxt;
    s1_k_r <= sc_r;
    if (s1_vld_r) begin
      win_up_r  <= win_mid_r;
      win_mid_r <= win_dn_r;
      win_dn_r  <= rd_data_r;
      win_k_r   <= s1_k_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `LGT_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, state_r != ST_IDLE, "item transfer did not leave idle")
  `LGT_ASSERT_IMP(a_win_row_in_board, clk, rst_n, win_vld_r, (win_k_r - SW'(2)) < hsw, "sweep wrote a row outside the board")
  `LGT_ASSERT_IMP(a_sweep_in_advance, clk, rst_n, s1_vld_r || win_vld_r, state_r == ST_ADV, "sweep data outside an advance")
  `LGT_ASSERT_IMP(a_bank_flip, clk, rst_n, bank_r != $past(bank_r), (state_r == ST_DONE) && (req_r.command == CMD_ADVANCE), "bank changed outside an advance")

endmodule

`default_nettype wire
